[sv/cfzr_pkg.sv]
// shared types, constants and generator tables for the cubic zone reduction block
package cfzr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_BITS = 30;
   localparam int FIELD_W   = 18;
   localparam int IDX_W     = 5;
   localparam int NUM_GEN   = 24;
   localparam int SUM_W     = FIELD_W + 3;
   localparam int MAG_W     = SUM_W - 1;
   localparam int KEY_W     = MAG_W + COEF_BITS;
   localparam int RND_W     = KEY_W - COEF_BITS + 1;

   // 1/sqrt(2) in q30, rounded to nearest
   localparam logic [COEF_BITS-1:0] C_HS2 = 30'd759250125;

   localparam int FIELD_MAX = 2 ** (FIELD_W - 1) - 1;
   localparam int FIELD_MIN_MAG = 2 ** (FIELD_W - 1);
   localparam int POS_LIMIT = (2 ** FRAC_BITS < FIELD_MAX) ? 2 ** FRAC_BITS : FIELD_MAX;
   localparam int NEG_LIMIT = (2 ** FRAC_BITS < FIELD_MIN_MAG) ? 2 ** FRAC_BITS : FIELD_MIN_MAG;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [1:0] sgn_type;

   localparam sgn_type SG_Z = 2'd0;
   localparam sgn_type SG_P = 2'd1;
   localparam sgn_type SG_N = 2'd2;

   typedef enum logic [1:0] {
      CLS_ONE,
      CLS_HALF,
      CLS_HS2
   } cls_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } cand_type;

   // coefficient signs of each generator, ordered w, x, y, z
   localparam sgn_type GEN_SIGN [NUM_GEN][4] = '{
      '{SG_P, SG_Z, SG_Z, SG_Z}, '{SG_Z, SG_P, SG_Z, SG_Z},
      '{SG_Z, SG_Z, SG_P, SG_Z}, '{SG_Z, SG_Z, SG_Z, SG_P},
      '{SG_P, SG_P, SG_P, SG_P}, '{SG_P, SG_P, SG_N, SG_P},
      '{SG_P, SG_N, SG_P, SG_P}, '{SG_P, SG_N, SG_N, SG_P},
      '{SG_N, SG_P, SG_P, SG_P}, '{SG_N, SG_P, SG_N, SG_P},
      '{SG_N, SG_N, SG_P, SG_P}, '{SG_N, SG_N, SG_N, SG_P},
      '{SG_P, SG_P, SG_Z, SG_Z}, '{SG_P, SG_Z, SG_P, SG_Z},
      '{SG_P, SG_Z, SG_Z, SG_P}, '{SG_N, SG_P, SG_Z, SG_Z},
      '{SG_N, SG_Z, SG_P, SG_Z}, '{SG_N, SG_Z, SG_Z, SG_P},
      '{SG_Z, SG_P, SG_P, SG_Z}, '{SG_Z, SG_P, SG_Z, SG_P},
      '{SG_Z, SG_Z, SG_P, SG_P}, '{SG_Z, SG_N, SG_P, SG_Z},
      '{SG_Z, SG_N, SG_Z, SG_P}, '{SG_Z, SG_Z, SG_N, SG_P}
   };

   localparam cls_type GEN_CLASS [NUM_GEN] = '{
      CLS_ONE, CLS_ONE, CLS_ONE, CLS_ONE,
      CLS_HALF, CLS_HALF, CLS_HALF, CLS_HALF,
      CLS_HALF, CLS_HALF, CLS_HALF, CLS_HALF,
      CLS_HS2, CLS_HS2, CLS_HS2, CLS_HS2, CLS_HS2, CLS_HS2,
      CLS_HS2, CLS_HS2, CLS_HS2, CLS_HS2, CLS_HS2, CLS_HS2
   };

   function automatic sum_type term(field_type q, sgn_type s);
      case (s)
         SG_P:    term = SUM_W'(q);
         SG_N:    term = -SUM_W'(q);
         default: term = '0;
      endcase
   endfunction

   function automatic logic [MAG_W-1:0] abs_sum(sum_type v);
      abs_sum = (v < 0) ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   // magnitude times the generator coefficient, q30 scale
   function automatic logic [KEY_W-1:0] scale_mag(cls_type c, logic [MAG_W-1:0] m);
      logic [KEY_W-1:0] ext;
      ext = KEY_W'(m);
      case (c)
         CLS_ONE:  scale_mag = ext << COEF_BITS;
         CLS_HALF: scale_mag = ext << (COEF_BITS - 1);
         default:  scale_mag = ext * KEY_W'(C_HS2);
      endcase
   endfunction

   // a holds the lower generator index, so it wins ties
   function automatic cand_type pick(cand_type a, cand_type b);
      pick = (b.key > a.key) ? b : a;
   endfunction

endpackage

[sv/cubic_fundamental_zone_reduce_top.sv]
// cubic fundamental zone reduction of one orientation quaternion per transfer
//
//  channel  direction  ports                                       transfer when
//  req      in         req_in_w/x/y/z                               req_valid & req_ready
//  rsp      out        rsp_out_w/x/y/z, rsp_gen_index, rsp_zero_error rsp_valid & rsp_ready
//
// eight register stages: input, real-part sums, scaled keys, two compare
// tree levels, product sums, scaled product, rounded output.
// one transfer per cycle sustained while rsp_ready stays high.
// each stage advances when it is empty or the next one moves, so bubbles
// are squeezed out while rsp stalls. reset clears only the valid bits.
module cubic_fundamental_zone_reduce_top import cfzr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  field_type        req_in_w,
   input  field_type        req_in_x,
   input  field_type        req_in_y,
   input  field_type        req_in_z,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output field_type        rsp_out_w,
   output field_type        rsp_out_x,
   output field_type        rsp_out_y,
   output field_type        rsp_out_z,
   output logic [IDX_W-1:0] rsp_gen_index,
   output logic             rsp_zero_error
);

   localparam int NUM_STAGES = 8;

   logic [NUM_STAGES-1:0] vld_ff, vld_in, en;

   field_type        q_ff [5][4];
   field_type        q_in [5][4];
   logic [MAG_W-1:0] mag1_ff [NUM_GEN];
   logic [MAG_W-1:0] mag1_in [NUM_GEN];
   cand_type         cand2_ff [NUM_GEN];
   cand_type         cand2_in [NUM_GEN];
   cand_type         cand3_ff [6];
   cand_type         cand3_in [6];
   cand_type         cand4_ff [2];
   cand_type         cand4_in [2];

   sum_type          d5_ff [4];
   sum_type          d5_in [4];
   logic             flip5_ff, flip5_in;
   cls_type          cls5_ff, cls5_in;
   logic [IDX_W-1:0] idx5_ff, idx5_in;
   logic             err5_ff, err5_in;

   logic [KEY_W-1:0] m6_ff [4];
   logic [KEY_W-1:0] m6_in [4];
   logic [3:0]       neg6_ff, neg6_in;
   logic [IDX_W-1:0] idx6_ff;
   logic             err6_ff;

   field_type        rnd7 [4];
   field_type        out_ff [4];
   field_type        out_in [4];
   logic [IDX_W-1:0] idx7_ff, idx7_in;
   logic             err7_ff;

   cand_type         best5;
   sgn_type          sg5 [4];

   // handshake chain
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // quaternion carried down to the product stage
   always_comb begin
      q_in[0][0] = req_in_w;
      q_in[0][1] = req_in_x;
      q_in[0][2] = req_in_y;
      q_in[0][3] = req_in_z;
      for (int k = 1; k < 5; k++) begin
         q_in[k] = q_ff[k-1];
      end
   end

   // absolute real part of q*g for every generator, before scaling
   always_comb begin
      for (int i = 0; i < NUM_GEN; i++) begin
         mag1_in[i] = abs_sum(term(q_ff[0][0], GEN_SIGN[i][0])
                            - term(q_ff[0][1], GEN_SIGN[i][1])
                            - term(q_ff[0][2], GEN_SIGN[i][2])
                            - term(q_ff[0][3], GEN_SIGN[i][3]));
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_GEN; i++) begin
         cand2_in[i].key = scale_mag(GEN_CLASS[i], mag1_ff[i]);
         cand2_in[i].idx = IDX_W'(i);
      end
   end

   // compare tree, lower index stays on the left of each pair
   always_comb begin
      for (int g = 0; g < 6; g++) begin
         cand3_in[g] = pick(pick(cand2_ff[4*g], cand2_ff[4*g+1]),
                            pick(cand2_ff[4*g+2], cand2_ff[4*g+3]));
      end
      cand4_in[0] = pick(pick(cand3_ff[0], cand3_ff[1]), cand3_ff[2]);
      cand4_in[1] = pick(pick(cand3_ff[3], cand3_ff[4]), cand3_ff[5]);
   end

   // product q*g with the winner, as signed sums of the components
   always_comb begin
      best5 = pick(cand4_ff[0], cand4_ff[1]);
      for (int j = 0; j < 4; j++) begin
         sg5[j] = GEN_SIGN[best5.idx][j];
      end
      d5_in[0] = term(q_ff[4][0], sg5[0]) - term(q_ff[4][1], sg5[1])
               - term(q_ff[4][2], sg5[2]) - term(q_ff[4][3], sg5[3]);
      d5_in[1] = term(q_ff[4][0], sg5[1]) + term(q_ff[4][1], sg5[0])
               + term(q_ff[4][2], sg5[3]) - term(q_ff[4][3], sg5[2]);
      d5_in[2] = term(q_ff[4][0], sg5[2]) - term(q_ff[4][1], sg5[3])
               + term(q_ff[4][2], sg5[0]) + term(q_ff[4][3], sg5[1]);
      d5_in[3] = term(q_ff[4][0], sg5[3]) + term(q_ff[4][1], sg5[2])
               - term(q_ff[4][2], sg5[1]) + term(q_ff[4][3], sg5[0]);
      flip5_in = d5_in[0] < 0;
      cls5_in  = GEN_CLASS[best5.idx];
      idx5_in  = best5.idx;
      err5_in  = best5.key == '0;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg6_in[i] = (d5_ff[i] < 0) ^ flip5_ff;
         m6_in[i]   = scale_mag(cls5_ff, abs_sum(d5_ff[i]));
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_round
      cfzr_round u_round (
         .neg (neg6_ff[i]),
         .mag (m6_ff[i]),
         .val (rnd7[i])
      );
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_in[i] = err6_ff ? '0 : rnd7[i];
      end
      idx7_in = err6_ff ? '0 : idx6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      for (int k = 0; k < 5; k++) begin
         if (en[k]) begin
            q_ff[k] <= q_in[k];
         end
      end
      if (en[1]) begin
         mag1_ff <= mag1_in;
      end
      if (en[2]) begin
         cand2_ff <= cand2_in;
      end
      if (en[3]) begin
         cand3_ff <= cand3_in;
      end
      if (en[4]) begin
         cand4_ff <= cand4_in;
      end
      if (en[5]) begin
         d5_ff    <= d5_in;
         flip5_ff <= flip5_in;
         cls5_ff  <= cls5_in;
         idx5_ff  <= idx5_in;
         err5_ff  <= err5_in;
      end
      if (en[6]) begin
         m6_ff   <= m6_in;
         neg6_ff <= neg6_in;
         idx6_ff <= idx5_ff;
         err6_ff <= err5_ff;
      end
      if (en[7]) begin
         out_ff  <= out_in;
         idx7_ff <= idx7_in;
         err7_ff <= err6_ff;
      end
   end

   assign rsp_out_w      = out_ff[0];
   assign rsp_out_x      = out_ff[1];
   assign rsp_out_y      = out_ff[2];
   assign rsp_out_z      = out_ff[3];
   assign rsp_gen_index  = idx7_ff;
   assign rsp_zero_error = err7_ff;

endmodule

[sv/cfzr_round.sv]
// rounds one q30-scaled magnitude to the field format and saturates it
module cfzr_round import cfzr_pkg::*; (
   input  logic             neg,
   input  logic [KEY_W-1:0] mag,
   output field_type        val
);

   logic [KEY_W:0]   sum_w;
   logic [RND_W-1:0] rnd;
   logic [RND_W-1:0] lim;
   logic [RND_W-1:0] clip;

   always_comb begin
      // halves away from zero since the sign is applied after rounding
      sum_w = {1'b0, mag} + ((KEY_W + 1)'(1) << (COEF_BITS - 1));
      rnd   = sum_w[KEY_W:COEF_BITS];
      lim   = neg ? RND_W'(NEG_LIMIT) : RND_W'(POS_LIMIT);
      clip  = (rnd > lim) ? lim : rnd;
      val   = neg ? -FIELD_W'(clip) : FIELD_W'(clip);
   end

endmodule

[tb/sv/cubic_fundamental_zone_reduce_top_tb.sv]
// self-checking testbench for the cubic fundamental zone reduction block
`timescale 1ns / 1ps

module cubic_fundamental_zone_reduce_top_tb import cfzr_pkg::*;;

   localparam longint K1 = 64'sd1073741824;
   localparam longint KH = 64'sd536870912;
   localparam longint KS = 64'sd759250125;
   localparam longint UNIT = 64'sd1 <<< FRAC_BITS;
   localparam int DRAIN_CYCLES = 16;

   // cubic symmetry generators in q30, ordered w, x, y, z
   localparam longint GEN_COEF [NUM_GEN][4] = '{
      '{K1, 0, 0, 0}, '{0, K1, 0, 0}, '{0, 0, K1, 0}, '{0, 0, 0, K1},
      '{KH, KH, KH, KH}, '{KH, KH, -KH, KH}, '{KH, -KH, KH, KH}, '{KH, -KH, -KH, KH},
      '{-KH, KH, KH, KH}, '{-KH, KH, -KH, KH}, '{-KH, -KH, KH, KH},
      '{-KH, -KH, -KH, KH},
      '{KS, KS, 0, 0}, '{KS, 0, KS, 0}, '{KS, 0, 0, KS},
      '{-KS, KS, 0, 0}, '{-KS, 0, KS, 0}, '{-KS, 0, 0, KS},
      '{0, KS, KS, 0}, '{0, KS, 0, KS}, '{0, 0, KS, KS},
      '{0, -KS, KS, 0}, '{0, -KS, 0, KS}, '{0, 0, -KS, KS}
   };

   typedef struct {
      field_type        w;
      field_type        x;
      field_type        y;
      field_type        z;
      logic [IDX_W-1:0] gen;
      logic             zerr;
   } reduced_quat_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   field_type        req_in_w;
   field_type        req_in_x;
   field_type        req_in_y;
   field_type        req_in_z;
   logic             rsp_valid;
   logic             rsp_ready;
   field_type        rsp_out_w;
   field_type        rsp_out_x;
   field_type        rsp_out_y;
   field_type        rsp_out_z;
   logic [IDX_W-1:0] rsp_gen_index;
   logic             rsp_zero_error;

   reduced_quat_type pending_rsp [$];
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               rsp_hold_left = 0;
   int               errors = 0;
   int               quats_sent = 0;
   int               rsp_checked = 0;
   int               zero_seen = 0;
   int               req_blocked_cycles = 0;
   logic [NUM_GEN-1:0] gen_seen = '0;

   cubic_fundamental_zone_reduce_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_w       (req_in_w),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .req_in_z       (req_in_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_w      (rsp_out_w),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_gen_index  (rsp_gen_index),
      .rsp_zero_error (rsp_zero_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // q(16+30) back to q16, halves away from zero, clamped to [-1, 1]
   function automatic field_type round_q16(longint v);
      longint mag;
      longint r;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS;
      r = (v < 0) ? -mag : mag;
      if (r > UNIT) r = UNIT;
      if (r < -UNIT) r = -UNIT;
      return field_type'(r);
   endfunction

   function automatic reduced_quat_type reduce_quat(field_type w, field_type x,
                                                    field_type y, field_type z);
      longint q [4];
      longint g [4];
      longint b [4];
      longint t;
      longint best;
      int bi;
      reduced_quat_type r;
      q[0] = w;
      q[1] = x;
      q[2] = y;
      q[3] = z;
      best = 0;
      bi = -1;
      for (int i = 0; i < NUM_GEN; i++) begin
         t = q[0] * GEN_COEF[i][0] - q[1] * GEN_COEF[i][1]
           - q[2] * GEN_COEF[i][2] - q[3] * GEN_COEF[i][3];
         if (t < 0) t = -t;
         // strictly larger only, so the lowest index keeps a tie
         if (t > best) begin
            best = t;
            bi = i;
         end
      end
      r.w = '0;
      r.x = '0;
      r.y = '0;
      r.z = '0;
      r.gen = '0;
      r.zerr = 1'b1;
      if (bi < 0) return r;
      for (int k = 0; k < 4; k++) g[k] = GEN_COEF[bi][k];
      b[0] = q[0] * g[0] - q[1] * g[1] - q[2] * g[2] - q[3] * g[3];
      b[1] = q[0] * g[1] + q[1] * g[0] + q[2] * g[3] - q[3] * g[2];
      b[2] = q[0] * g[2] - q[1] * g[3] + q[2] * g[0] + q[3] * g[1];
      b[3] = q[0] * g[3] + q[1] * g[2] - q[2] * g[1] + q[3] * g[0];
      if (b[0] < 0)
         for (int k = 0; k < 4; k++) b[k] = -b[k];
      r.w = round_q16(b[0]);
      r.x = round_q16(b[1]);
      r.y = round_q16(b[2]);
      r.z = round_q16(b[3]);
      r.gen = IDX_W'(bi);
      r.zerr = 1'b0;
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_quat(input field_type w, input field_type x,
                            input field_type y, input field_type z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_w <= w;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(reduce_quat(w, x, y, z));
      quats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // output side: long hold when asked, otherwise random stalls
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      reduced_quat_type e;
      if (!reset && req_valid && !req_ready) req_blocked_cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer: w=%0d gen=%0d", rsp_out_w, rsp_gen_index);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            rsp_checked++;
            if (rsp_zero_error) zero_seen++;
            else if (rsp_gen_index < NUM_GEN) gen_seen[rsp_gen_index] = 1'b1;
            if (rsp_out_w !== e.w) begin
               $error("out_w mismatch: expected %0d, got %0d", e.w, rsp_out_w);
               errors++;
            end
            if (rsp_out_x !== e.x) begin
               $error("out_x mismatch: expected %0d, got %0d", e.x, rsp_out_x);
               errors++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y mismatch: expected %0d, got %0d", e.y, rsp_out_y);
               errors++;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z mismatch: expected %0d, got %0d", e.z, rsp_out_z);
               errors++;
            end
            if (rsp_gen_index !== e.gen) begin
               $error("gen_index mismatch: expected %0d, got %0d", e.gen, rsp_gen_index);
               errors++;
            end
            if (rsp_zero_error !== e.zerr) begin
               $error("zero_error mismatch: expected %0d, got %0d", e.zerr,
                      rsp_zero_error);
               errors++;
            end
         end
      end
   end

   task automatic test_corner_cases();
      send_quat(0, 0, 0, 0);
      send_quat(65536, 0, 0, 0);
      send_quat(-65536, 0, 0, 0);
      send_quat(0, 65536, 0, 0);
      send_quat(0, 0, -65536, 0);
      send_quat(0, 0, 0, 65536);
      // out of range patterns, result must saturate; then two unit quaternions
      send_quat(131071, 131071, 131071, 131071);
      send_quat(-131072, -131072, -131072, -131072);
      send_quat(131071, -131072, 0, 0);
      send_quat(-131072, 131071, -131072, 131071);
      send_quat(32768, 32768, 32768, 32768);
      send_quat(32768, -32768, 32768, -32768);
   endtask

   task automatic test_ties_and_rounding();
      // equal components give several generators the same real part
      send_quat(1, 1, 1, 1);
      send_quat(0, 1, 1, 0);
      send_quat(5, 5, 0, 0);
      send_quat(1, 0, 0, 1);
      // half coefficients on odd values land exactly on a rounding half
      send_quat(1, 1, 1, 0);
      send_quat(-1, -1, -1, 0);
      send_quat(3, -1, 1, 1);
      send_quat(46341, 46341, 0, 0);
      send_quat(-46341, 0, 46341, 0);
   endtask

   task automatic test_random_stream(input int count, input int idle_pct,
                                     input int stall_pct);
      int mode;
      int a;
      int v [4];
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(99);
         a = $urandom_range(65536);
         for (int k = 0; k < 4; k++) begin
            if (mode < 30) v[k] = $urandom();
            else if (mode < 60) v[k] = int'($urandom_range(131072)) - 65536;
            else if (mode < 75) v[k] = int'($urandom_range(8)) - 4;
            else if (mode < 98) begin
               // components from {0, a, -a} stress ties between generators
               case ($urandom_range(2))
                  0: v[k] = 0;
                  1: v[k] = a;
                  default: v[k] = -a;
               endcase
            end else v[k] = 0;
         end
         send_quat(field_type'(v[0]), field_type'(v[1]), field_type'(v[2]),
                   field_type'(v[3]));
      end
      wait_drained();
   endtask

   task automatic test_output_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 80;
      // keep offering while the output is held so the pipeline backs up
      for (int n = 0; n < 40; n++)
         send_quat(field_type'($urandom()), field_type'($urandom()),
                   field_type'($urandom()), field_type'($urandom()));
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_w = '0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      rsp_ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_cases();
      test_ties_and_rounding();
      wait_drained();
      test_random_stream(450, 0, 0);
      test_random_stream(450, 62, 0);
      test_random_stream(450, 0, 62);
      test_random_stream(450, 20, 20);
      test_output_stall();

      if (pending_rsp.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         errors++;
      end
      $display("%0d quaternions sent, %0d results checked, %0d zero inputs flagged",
               quats_sent, rsp_checked, zero_seen);
      $display("%0d of %0d generators chosen; input held off for %0d cycles under stalls",
               $countones(gen_seen), NUM_GEN, req_blocked_cycles);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
sv/cfzr_pkg.sv
sv/cfzr_round.sv
sv/cubic_fundamental_zone_reduce_top.sv
tb/sv/cubic_fundamental_zone_reduce_top_tb.sv
